// ===== design/lsh_pkg.sv =====
// Package for the link setup handshake: frame constants, command and event codes,
// the per-word step result passed from the controller to the output stage.
// No dependencies.
`default_nettype none

package lsh_pkg;

  localparam logic [7:0] FRAME_FLAG = 8'h7E;
  localparam logic [7:0] CTRL_SET   = 8'h03;
  localparam logic [7:0] CTRL_UA    = 8'h07;

  localparam int unsigned FRAME_LEN = 5;
  localparam int unsigned POS_W     = 3;

  // Command codes of an input word
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_SPARE = 2'd3
  } cmd_t;

  // Event codes of a result word
  typedef enum logic [1:0] {
    EV_TX   = 2'd0,
    EV_UP   = 2'd1,
    EV_FAIL = 2'd2
  } event_t;

  // Configuration register indexes
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd0;
  localparam logic [1:0] REG_MAX_ATTEMPTS  = 2'd1;
  localparam logic [1:0] REG_ADDRESS_BYTE  = 2'd2;

  // What one accepted input word produces
  typedef struct packed {
    logic   send_frame;  // five SET frame bytes
    logic   send_event;  // one status word
    event_t ev;          // status code when send_event is set
  } step_res_t;

  // Byte at a given position of a SET frame
  function automatic logic [7:0] set_frame_byte(input logic [POS_W-1:0] pos,
                                                input logic [7:0] addr);
    logic [7:0] b;
    b = FRAME_FLAG;
    unique case (pos)
      3'd0:    b = FRAME_FLAG;
      3'd1:    b = addr;
      3'd2:    b = CTRL_SET;
      3'd3:    b = addr ^ CTRL_SET;
      3'd4:    b = FRAME_FLAG;
      default: b = FRAME_FLAG;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== design/lsh_ctrl.sv =====
// Handshake controller: UA recognizer, link phase, tick and timeout counters.
// Decides per input word what results follow. Depends on lsh_pkg.
`default_nettype none

module lsh_ctrl import lsh_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic [7:0] timeout_ticks,
  input  wire logic [3:0] max_attempts,
  input  wire logic [7:0] address_byte,
  input  wire logic      accept,
  input  wire logic [1:0] command,
  input  wire logic [7:0] rx_byte,
  output step_res_t      res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_UP   = 2'd2,
    PH_FAIL = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    RX_FLAG  = 3'd0,
    RX_ADDR  = 3'd1,
    RX_CTRL  = 3'd2,
    RX_CHECK = 3'd3,
    RX_END   = 3'd4
  } rx_state_t;

  rx_state_t   recv_state, recv_state_next;
  phase_t      link_phase, link_phase_next;
  logic [7:0]  tick_count, tick_count_next;
  logic [3:0]  timeout_count, timeout_count_next;

  logic [7:0]  tick_inc;
  logic [3:0]  to_inc;
  rx_state_t   restart;

  assign tick_inc = tick_count + 8'd1;
  assign to_inc   = timeout_count + 4'd1;
  assign restart  = (rx_byte == FRAME_FLAG) ? RX_ADDR : RX_FLAG;

  // Work out next state and results of the presented word
  always_comb begin
    recv_state_next    = recv_state;
    link_phase_next    = link_phase;
    tick_count_next    = tick_count;
    timeout_count_next = timeout_count;
    res                = '{send_frame: 1'b0, send_event: 1'b0, ev: EV_TX};
    if (command == CMD_START) begin
      recv_state_next    = RX_FLAG;
      tick_count_next    = '0;
      timeout_count_next = '0;
      link_phase_next    = PH_WAIT;
      res.send_frame     = 1'b1;
    end else if (link_phase == PH_WAIT && command == CMD_BYTE) begin
      unique case (recv_state)
        RX_ADDR:  recv_state_next = (rx_byte == address_byte) ? RX_CTRL : restart;
        RX_CTRL:  recv_state_next = (rx_byte == CTRL_UA) ? RX_CHECK : restart;
        RX_CHECK: recv_state_next = (rx_byte == (address_byte ^ CTRL_UA)) ? RX_END : restart;
        RX_END: begin
          recv_state_next = RX_FLAG;
          if (rx_byte == FRAME_FLAG) begin
            link_phase_next = PH_UP;
            res.send_event  = 1'b1;
            res.ev          = EV_UP;
          end
        end
        default:  recv_state_next = restart;
      endcase
    end else if (link_phase == PH_WAIT && command == CMD_TICK) begin
      if (tick_inc < timeout_ticks) begin
        tick_count_next = tick_inc;
      end else begin
        tick_count_next    = '0;
        timeout_count_next = to_inc;
        if (to_inc >= max_attempts) begin
          link_phase_next = PH_FAIL;
          res.send_event  = 1'b1;
          res.ev          = EV_FAIL;
        end else begin
          res.send_frame = 1'b1;
        end
      end
    end
  end

  // Hold state; advance on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      recv_state    <= RX_FLAG;
      link_phase    <= PH_IDLE;
      tick_count    <= '0;
      timeout_count <= '0;
    end else if (accept) begin
      recv_state    <= recv_state_next;
      link_phase    <= link_phase_next;
      tick_count    <= tick_count_next;
      timeout_count <= timeout_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/link_setup_handshake.sv =====
// Top level of the link setup handshake: configuration registers, controller
// and the registered output stage that plays out frames. Depends on lsh_pkg, lsh_ctrl.
`default_nettype none

// Sender side of a SET/UA link setup. Each input word (start, received byte, timer
// tick) is decided in the cycle it is accepted; one input word can be taken every
// cycle while in_stall is low. A start or a resend after a timeout yields five output
// words (the SET frame), one per cycle from the output register while out_stall is
// low; link up and link failed yield one word each, with last set on the final word.
// A word that yields results is stalled only while the output register still holds
// words of an earlier item that will not all be taken in that cycle. Words that yield
// nothing (most received bytes and ticks) are taken at once, even while output is
// stalled. Registers are written through cfg_we/cfg_index/cfg_data by the user, who
// must do so only while the block is idle; the block itself does not enforce this.
module link_setup_handshake import lsh_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] command,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      event_res,
  output logic [7:0]      tx_byte,
  output logic            last
);

  logic [7:0]       timeout_ticks;
  logic [3:0]       max_attempts;
  logic [7:0]       address_byte;
  logic [POS_W-1:0] pos;
  step_res_t        res;
  logic             has_result;
  logic             advance;
  logic             out_free;
  logic             accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= 8'd3;
      max_attempts  <= 4'd3;
      address_byte  <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        REG_MAX_ATTEMPTS:  max_attempts  <= cfg_data[3:0];
        REG_ADDRESS_BYTE:  address_byte  <= cfg_data;
        default: ;
      endcase
    end
  end

  lsh_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .timeout_ticks (timeout_ticks),
    .max_attempts  (max_attempts),
    .address_byte  (address_byte),
    .accept        (accept),
    .command       (command),
    .rx_byte       (rx_byte),
    .res           (res)
  );

  // Stall only a word with results while the output stage is busy
  assign has_result = res.send_frame | res.send_event;
  assign advance    = out_valid & ~out_stall;
  assign out_free   = ~out_valid | (advance & last);
  assign in_stall   = has_result & ~out_free;
  assign accept     = in_valid & ~in_stall;

  // Output register: load a new item, step through a frame, drop when done
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last      <= 1'b0;
      pos       <= '0;
      event_res <= EV_TX;
      tx_byte   <= '0;
    end else if (accept && res.send_frame) begin
      out_valid <= 1'b1;
      event_res <= EV_TX;
      tx_byte   <= set_frame_byte(POS_W'(0), address_byte);
      last      <= 1'b0;
      pos       <= POS_W'(1);
    end else if (accept && res.send_event) begin
      out_valid <= 1'b1;
      event_res <= res.ev;
      tx_byte   <= '0;
      last      <= 1'b1;
    end else if (advance && !last) begin
      tx_byte   <= set_frame_byte(pos, address_byte);
      last      <= (pos == POS_W'(FRAME_LEN - 1));
      pos       <= pos + POS_W'(1);
    end else if (advance) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== test/link_setup_handshake_test.sv =====
`timescale 1ns / 100ps
// Testbench for link_setup_handshake: queue-fed driver, output monitor and a SET/UA predictor.
// Depends on lsh_pkg and the link_setup_handshake top level.

module link_setup_handshake_test;
  import lsh_pkg::*;

  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {
    LINK_IDLE   = 2'd0,
    LINK_WAIT   = 2'd1,
    LINK_UP     = 2'd2,
    LINK_FAILED = 2'd3
  } link_t;

  // UA recognizer positions
  localparam logic [2:0] RS_IDLE  = 3'd0;
  localparam logic [2:0] RS_FLAG  = 3'd1;
  localparam logic [2:0] RS_ADDR  = 3'd2;
  localparam logic [2:0] RS_CTRL  = 3'd3;
  localparam logic [2:0] RS_CHECK = 3'd4;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } word_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] data;
    logic       tail;
  } res_word_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_TIMEOUT_TICKS;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] command = CMD_SPARE;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] event_res;
  logic [7:0] tx_byte;
  logic       last;

  link_setup_handshake dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .event_res (event_res),
    .tx_byte   (tx_byte),
    .last      (last)
  );

  // Pending input words and expected result words
  word_t     word_q[$];
  res_word_t frame_q[$];

  // Predictor copy of registers and state
  logic [7:0] reg_ticks    = 8'd3;
  logic [3:0] reg_attempts = 4'd3;
  logic [7:0] reg_addr     = 8'd3;
  logic [2:0] rx_pos       = RS_IDLE;
  link_t      link         = LINK_IDLE;
  logic [7:0] tick_cnt     = 8'd0;
  logic [3:0] timeout_cnt  = 4'd0;

  bit        calm = 1'b0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        errors = 0;
  int        queued_words = 0;
  int        words_taken = 0;
  int        results_seen = 0;
  int        ups_seen = 0;
  int        fails_seen = 0;
  word_t     next_word;
  res_word_t want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void expect_word(input event_t ev, input logic [7:0] data,
                                      input logic tail);
    res_word_t w;
    w.ev = ev;
    w.data = data;
    w.tail = tail;
    frame_q.push_back(w);
  endfunction

  function automatic void expect_set_frame();
    expect_word(EV_TX, FRAME_FLAG, 1'b0);
    expect_word(EV_TX, reg_addr, 1'b0);
    expect_word(EV_TX, CTRL_SET, 1'b0);
    expect_word(EV_TX, reg_addr ^ CTRL_SET, 1'b0);
    expect_word(EV_TX, FRAME_FLAG, 1'b1);
  endfunction

  // Advance the UA recognizer by one byte; return 1 when a frame completes
  function automatic logic ua_step(input logic [7:0] b);
    logic [2:0] miss;
    logic       done;
    miss = (b == FRAME_FLAG) ? RS_FLAG : RS_IDLE;
    done = 1'b0;
    case (rx_pos)
      RS_FLAG:  rx_pos = (b == reg_addr) ? RS_ADDR : miss;
      RS_ADDR:  rx_pos = (b == CTRL_UA) ? RS_CTRL : miss;
      RS_CTRL:  rx_pos = (b == (reg_addr ^ CTRL_UA)) ? RS_CHECK : miss;
      RS_CHECK: begin
        rx_pos = RS_IDLE;
        done = (b == FRAME_FLAG);
      end
      default:  rx_pos = miss;
    endcase
    return done;
  endfunction

  // Work out the result words of one accepted input word
  function automatic void predict_handshake(input logic [1:0] cmd, input logic [7:0] b);
    if (cmd == CMD_START) begin
      rx_pos = RS_IDLE;
      tick_cnt = 8'd0;
      timeout_cnt = 4'd0;
      link = LINK_WAIT;
      expect_set_frame();
    end else if (link == LINK_WAIT) begin
      if (cmd == CMD_BYTE) begin
        if (ua_step(b)) begin
          link = LINK_UP;
          expect_word(EV_UP, 8'h00, 1'b1);
        end
      end else if (cmd == CMD_TICK) begin
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt >= reg_ticks) begin
          tick_cnt = 8'd0;
          timeout_cnt = timeout_cnt + 4'd1;
          if (timeout_cnt >= reg_attempts) begin
            link = LINK_FAILED;
            expect_word(EV_FAIL, 8'h00, 1'b1);
          end else begin
            expect_set_frame();
          end
        end
      end
    end
  endfunction

  // Input driver: present queued words, with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left == 0 && !calm && $urandom_range(0, 7) == 0)
        gap_left = $urandom_range(1, 16);
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (word_q.size() > 0) begin
        next_word = word_q.pop_front();
        in_valid <= 1'b1;
        command <= next_word.cmd;
        rx_byte <= next_word.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall in random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 16);
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predict on input accept, compare on output accept
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_handshake(command, rx_byte);
        words_taken++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (frame_q.size() == 0) begin
          $error("unexpected result word: event_res=%0d tx_byte=%h last=%0d",
                 event_res, tx_byte, last);
          errors++;
        end else begin
          want = frame_q.pop_front();
          if (want.ev == EV_UP) ups_seen++;
          if (want.ev == EV_FAIL) fails_seen++;
          if (event_res !== want.ev) begin
            $error("event_res: expected %0d, actual %0d", want.ev, event_res);
            errors++;
          end
          if (tx_byte !== want.data) begin
            $error("tx_byte: expected %h, actual %h", want.data, tx_byte);
            errors++;
          end
          if (last !== want.tail) begin
            $error("last: expected %0d, actual %0d", want.tail, last);
            errors++;
          end
        end
      end
    end
  end

  task automatic queue_word(input cmd_t c, input logic [7:0] d);
    word_t w;
    w.cmd = c;
    w.data = d;
    word_q.push_back(w);
    queued_words++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] ticks, input logic [3:0] attempts,
                            input logic [7:0] addr);
    write_reg(REG_TIMEOUT_TICKS, ticks);
    write_reg(REG_MAX_ATTEMPTS, {4'h0, attempts});
    write_reg(REG_ADDRESS_BYTE, addr);
    reg_ticks = ticks;
    reg_attempts = attempts;
    reg_addr = addr;
    @(negedge clk);
  endtask

  // Wait until every word is taken and every result has come, then let the block settle
  task automatic settle();
    while (word_q.size() != 0 || in_valid || frame_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed sessions: starts, UA frames, tick runs; some noise and broken frames
  task automatic queue_traffic(input int target);
    int         stop;
    int         r;
    int         i;
    int         n;
    int         bad;
    logic [7:0] b;
    stop = queued_words + target;
    while (queued_words < stop) begin
      r = $urandom_range(0, 15);
      if (r < 3) begin
        queue_word(CMD_START, 8'($urandom_range(0, 255)));
      end else if (r < 8) begin
        bad = (r == 7) ? $urandom_range(0, 4) : 5;
        for (i = 0; i < 5; i++) begin
          case (i)
            0, 4:    b = FRAME_FLAG;
            1:       b = reg_addr;
            2:       b = CTRL_UA;
            default: b = reg_addr ^ CTRL_UA;
          endcase
          if (i == bad) b = 8'($urandom_range(0, 255));
          queue_word(CMD_BYTE, b);
          if ($urandom_range(0, 7) == 0) queue_word(CMD_TICK, 8'($urandom_range(0, 255)));
        end
      end else if (r < 11) begin
        n = $urandom_range(1, reg_ticks + 1);
        if (n > stop - queued_words) n = stop - queued_words;
        for (i = 0; i < n; i++) queue_word(CMD_TICK, 8'($urandom_range(0, 255)));
      end else if (r < 12) begin
        // long enough to run out of attempts, within the word budget of this stretch
        n = ((reg_ticks == 0) ? 1 : reg_ticks) * (reg_attempts + 1);
        if (n > stop - queued_words) n = stop - queued_words;
        for (i = 0; i < n; i++) queue_word(CMD_TICK, 8'h00);
      end else if (r < 15) begin
        b = ($urandom_range(0, 3) == 0) ? FRAME_FLAG : 8'($urandom_range(0, 255));
        queue_word(CMD_BYTE, b);
      end else begin
        queue_word(CMD_SPARE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int p;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: ignored words, link up, resend keeping the recognizer position
    queue_word(CMD_BYTE, FRAME_FLAG);
    queue_word(CMD_TICK, 8'h00);
    queue_word(CMD_SPARE, 8'hFF);
    queue_word(CMD_START, 8'h00);
    queue_word(CMD_BYTE, FRAME_FLAG);
    queue_word(CMD_BYTE, 8'h03);
    queue_word(CMD_BYTE, CTRL_UA);
    queue_word(CMD_BYTE, 8'h03 ^ CTRL_UA);
    queue_word(CMD_BYTE, FRAME_FLAG);
    queue_word(CMD_START, 8'hFF);
    queue_word(CMD_BYTE, FRAME_FLAG);
    queue_word(CMD_BYTE, 8'h03);
    queue_word(CMD_SPARE, 8'h00);
    queue_word(CMD_TICK, 8'h00);
    queue_word(CMD_TICK, 8'hFF);
    queue_word(CMD_TICK, 8'h00);
    queue_word(CMD_BYTE, CTRL_UA);
    queue_word(CMD_BYTE, 8'h03 ^ CTRL_UA);
    queue_word(CMD_BYTE, FRAME_FLAG);
    queue_word(CMD_TICK, 8'h00);
    settle();

    // Zero ticks and attempts, address equal to the flag, non-flag after the check byte
    set_config(8'd0, 4'd0, FRAME_FLAG);
    queue_word(CMD_START, 8'h00);
    queue_word(CMD_BYTE, FRAME_FLAG);
    queue_word(CMD_BYTE, FRAME_FLAG);
    queue_word(CMD_BYTE, CTRL_UA);
    queue_word(CMD_BYTE, FRAME_FLAG ^ CTRL_UA);
    queue_word(CMD_BYTE, 8'h00);
    queue_word(CMD_TICK, 8'h00);
    settle();

    set_config(8'd1, 4'd15, 8'h00);
    queue_traffic(60);
    settle();

    set_config(8'd255, 4'd1, 8'hFF);
    queue_traffic(40);
    settle();

    for (p = 0; p < 3; p++) begin
      set_config(8'($urandom_range(1, 8)), 4'($urandom_range(1, 15)),
                 8'($urandom_range(0, 255)));
      queue_traffic(50);
      settle();
    end

    // Final stretch at full rate
    calm = 1'b1;
    set_config(8'($urandom_range(1, 6)), 4'($urandom_range(1, 15)),
               8'($urandom_range(0, 255)));
    queue_traffic(60);
    settle();

    $display("Ran %0d input words through eight register settings, checked %0d result words",
             words_taken, results_seen);
    $display("including %0d link-up and %0d setup-failed reports.", ups_seen, fails_seen);
    if (errors == 0) begin
      $display("link_setup_handshake test passed");
    end else begin
      $display("link_setup_handshake test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("link_setup_handshake test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/lsh_pkg.sv
design/lsh_ctrl.sv
design/link_setup_handshake.sv
test/link_setup_handshake_test.sv
